@@ rtl/sbde_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbde_pkg
// Shared types, character codes and the per-character encode function of the
// SMTP body dot-stuffing encoder.
// ----------------------------------------------------------------------------
package sbde_pkg;

    typedef logic [7:0] char_t;

    // Character codes
    localparam char_t CH_CR  = 8'h0D;
    localparam char_t CH_LF  = 8'h0A;
    localparam char_t CH_DOT = 8'h2E;

    // Raw history pattern CR LF CR (oldest in the high byte)
    localparam logic [23:0] HIST_CRLFCR = {CH_CR, CH_LF, CH_CR};

    // Most output characters one input can cause, and the count width
    localparam int BUF_DEPTH = 11;
    localparam int CNT_W     = 4;

    // Per-message state
    typedef struct packed {
        char_t       la0;         // oldest lookahead character
        char_t       la1;         // newer lookahead character
        logic [1:0]  la_cnt;      // valid lookahead characters, 0..2
        logic        prev_lf;     // last handled raw character was LF
        logic        prev_cr;     // last handled raw character was CR
        logic [23:0] hist;        // last three raw characters
        logic        header_done; // CR LF CR LF seen
    } msg_state_t;

    localparam msg_state_t MSG_RESET = '0;

    // Output of encoding one character: zero to two wire characters
    typedef struct packed {
        logic [1:0] len;
        char_t      b0;
        char_t      b1;
        logic       prev_lf;
        logic       prev_cr;
        logic       skip2;        // soft break deleted, two more consumed
    } piece_t;

    // Full result list of one input transaction
    typedef struct packed {
        logic [BUF_DEPTH-1:0][7:0] bytes;   // entry 0 goes out first
        logic [CNT_W-1:0]          count;
        logic                      msg_end; // final entry ends the message
    } result_t;

    // Encode one character given the previous-character flags
    function automatic piece_t enc_char(char_t c, logic plf, logic pcr, logic soft_brk);
        piece_t p;
        p         = '0;
        p.b0      = c;
        p.b1      = c;
        p.prev_lf = (c == CH_LF);
        p.prev_cr = (c == CH_CR);
        if (c == CH_DOT) begin
            p.b0 = CH_DOT;
            p.b1 = CH_DOT;
            p.len = plf ? 2'd2 : 2'd1;
        end else if (c == CH_CR) begin
            if (soft_brk) begin
                p.skip2   = 1'b1;
                p.prev_lf = 1'b1;
                p.prev_cr = 1'b0;
            end else if (!pcr) begin
                p.len = 2'd1;
            end
        end else if (c == CH_LF && !pcr) begin
            p.b0  = CH_CR;
            p.b1  = CH_LF;
            p.len = 2'd2;
        end else begin
            p.len = 2'd1;
        end
        return p;
    endfunction

endpackage

@@ rtl/sbde_encode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbde_encode
// Combinational step: from the message state, the mode and one input
// character, builds the list of wire characters and the next state.
// ----------------------------------------------------------------------------
module sbde_encode
    import sbde_pkg::*;
(
    input  msg_state_t st,
    input  logic       mode,
    input  char_t      x,
    input  logic       last,
    output result_t    res,
    output msg_state_t st_next
);

    char_t            q [3];
    logic [1:0]       cnt;
    logic             hd;
    logic [23:0]      hist_n;
    logic             soft_brk;
    piece_t           p0, p1, p2;
    piece_t           pc [3];
    logic             fin_lf;
    logic             term_en;
    logic             term_crlf;
    logic [CNT_W-1:0] n;

    always_comb begin
        // Queue of waiting characters followed by the new one
        q[0] = x;
        q[1] = x;
        q[2] = x;
        case (st.la_cnt)
            2'd0: begin
                cnt = 2'd1;
            end
            2'd1: begin
                q[0] = st.la0;
                cnt  = 2'd2;
            end
            default: begin
                q[0] = st.la0;
                q[1] = st.la1;
                cnt  = 2'd3;
            end
        endcase

        // Header end search on the raw stream
        hd     = st.header_done | ((st.hist == HIST_CRLFCR) && (x == CH_LF));
        hist_n = {st.hist[15:0], x};

        // Soft break CR CR LF only with both followers present
        soft_brk = (cnt == 2'd3) && !hd && (q[1] == CH_CR) && (q[2] == CH_LF);
        p0 = enc_char(q[0], st.prev_lf, st.prev_cr, soft_brk);
        p1 = enc_char(q[1], p0.prev_lf, p0.prev_cr, 1'b0);
        p2 = enc_char(q[2], p1.prev_lf, p1.prev_cr, 1'b0);

        for (int i = 0; i < 3; i++) begin
            pc[i] = '0;
        end
        st_next   = st;
        term_en   = 1'b0;
        term_crlf = 1'b0;
        fin_lf    = 1'b0;
        res       = '0;

        if (mode) begin
            // Pass-through: flush lookahead, then the new character
            for (int i = 0; i < 3; i++) begin
                pc[i].b0  = q[i];
                pc[i].len = (2'(i) < cnt) ? 2'd1 : 2'd0;
            end
            st_next.la_cnt = 2'd0;
            if (last) begin
                st_next     = MSG_RESET;
                res.msg_end = 1'b1;
            end
        end else if (!last) begin
            // Mid-message: encode the oldest once the lookahead is full
            st_next.hist        = hist_n;
            st_next.header_done = hd;
            if (cnt == 2'd3) begin
                pc[0]           = p0;
                st_next.prev_lf = p0.prev_lf;
                st_next.prev_cr = p0.prev_cr;
                if (p0.skip2) begin
                    st_next.la_cnt = 2'd0;
                end else begin
                    st_next.la_cnt = 2'd2;
                    st_next.la0    = q[1];
                    st_next.la1    = q[2];
                end
            end else begin
                st_next.la_cnt = cnt;
                st_next.la0    = q[0];
                st_next.la1    = q[1];
            end
        end else begin
            // Message end: drain the queue and append the terminator
            pc[0] = p0;
            if (p0.skip2) begin
                fin_lf = 1'b1;
            end else begin
                if (cnt != 2'd1) begin
                    pc[1] = p1;
                end
                if (cnt == 2'd3) begin
                    pc[2] = p2;
                end
                case (cnt)
                    2'd1:    fin_lf = p0.prev_lf;
                    2'd2:    fin_lf = p1.prev_lf;
                    default: fin_lf = p2.prev_lf;
                endcase
            end
            term_en     = 1'b1;
            term_crlf   = !fin_lf;
            res.msg_end = 1'b1;
            st_next     = MSG_RESET;
        end

        // Pack the pieces and terminator into the result list
        n = '0;
        for (int i = 0; i < 3; i++) begin
            if (pc[i].len != 2'd0) begin
                res.bytes[n] = pc[i].b0;
                n = n + 1'b1;
            end
            if (pc[i].len == 2'd2) begin
                res.bytes[n] = pc[i].b1;
                n = n + 1'b1;
            end
        end
        if (term_en) begin
            if (term_crlf) begin
                res.bytes[n] = CH_CR;
                n = n + 1'b1;
                res.bytes[n] = CH_LF;
                n = n + 1'b1;
            end
            res.bytes[n] = CH_DOT;
            n = n + 1'b1;
            res.bytes[n] = CH_CR;
            n = n + 1'b1;
            res.bytes[n] = CH_LF;
            n = n + 1'b1;
        end
        res.count = n;
    end

endmodule

@@ rtl/sbde_outbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbde_outbuf
// Result register: holds the character list of one input transaction and
// shifts it out one character per output transaction.
// ----------------------------------------------------------------------------
module sbde_outbuf
    import sbde_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res,
    output logic    can_load,
    output logic    m_tvalid,
    input  logic    m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic    m_tlast,      // run_last
    output logic    m_tuser       // [0] message_end
);

    logic [BUF_DEPTH-1:0][7:0] bytes_reg, bytes_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      end_reg, end_next;
    logic                      pop;

    assign pop      = m_tvalid && m_tready;
    assign can_load = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_tready);

    // Load a new list or shift the head out
    always_comb begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        end_next   = end_reg;
        if (load) begin
            bytes_next = res.bytes;
            cnt_next   = res.count;
            end_next   = res.msg_end;
        end else if (pop) begin
            bytes_next = bytes_reg >> 8;
            cnt_next   = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            end_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            end_reg <= end_next;
        end
        bytes_reg <= bytes_next;
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = bytes_reg[0];
    assign m_tlast  = (cnt_reg == CNT_W'(1));
    assign m_tuser  = m_tlast && end_reg;

endmodule

@@ rtl/smtp_body_dot_stuff_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtp_body_dot_stuff_encoder
// Turns message characters into the SMTP DATA wire stream: dot stuffing,
// CR/LF normalization, header soft-break removal and the end terminator,
// or plain pass-through in chunking mode.
//
//   channel  dir  payload                               handshake
//   s_       in   tdata[7:0] data_byte, tlast last      s_tvalid/s_tready
//   m_       out  tdata[7:0] out_byte, tlast run_last,  m_tvalid/m_tready
//                 tuser[0] message_end
//   cfg_     in   cfg_data[0] chunking_mode             cfg_valid/cfg_ready
//
// One output character leaves per cycle while m_tready is high; the result
// count of an input transaction is 0..11, usually 1 or 2.
// The result register is the limit: a new input is taken in the cycle its
// last character is accepted, or at once when the register is empty.
// Reset (aresetn low at a clock edge) clears mode, message state and the
// result register. Output stalls hold the list; input waits meanwhile.
// ----------------------------------------------------------------------------
module smtp_body_dot_stuff_encoder
    import sbde_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,    // [0] chunking_mode
    // Input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_byte
    input  logic       s_tlast,     // last
    // Output stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_byte
    output logic       m_tlast,     // run_last
    output logic       m_tuser      // [0] message_end
);

    msg_state_t st_reg, st_next;
    logic       mode_reg, mode_next;
    result_t    res;
    logic       can_load;
    logic       s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_load;
    assign s_accept  = s_tvalid && s_tready;

    // Per-character encode
    sbde_encode u_encode (
        .st      (st_reg),
        .mode    (mode_reg),
        .x       (s_tdata),
        .last    (s_tlast),
        .res     (res),
        .st_next (st_next)
    );

    // Result register and output side
    sbde_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_accept),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Mode register
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    // Message state and mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= MSG_RESET;
            mode_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            if (s_accept) begin
                st_reg <= st_next;
            end
        end
    end

    // An input is taken only when the pending list ends this cycle
    a_load_at_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast && m_tready)
        else $error("input accepted while results still pending");

    // Message end marks only the final character of a transaction
    a_end_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("message_end without run_last");

    // A message-ending input always produces output
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("last input produced no result");

    // Lookahead never holds more than two characters
    a_la_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.la_cnt != 2'd3)
        else $error("lookahead count out of range");

endmodule
